// ===== src/tcw_pkg.sv =====
// tcw_pkg: shared types and constants of the text console writer
// no dependencies; used by tcw_cell_ram, text_console_writer_core and the sim files
`default_nettype none

package tcw_pkg;

	localparam int ACTION_W     = 2;
	localparam int CHAR_W       = 8;
	localparam int ATTR_W       = 8;
	localparam int CELL_INDEX_W = 11;
	localparam int CURSOR_COL_W = 7;
	localparam int CURSOR_ROW_W = 5;
	localparam int CELL_W       = CHAR_W + ATTR_W;

	typedef logic [ACTION_W-1:0] action_t;
	typedef logic [CHAR_W-1:0]   char_t;
	typedef logic [ATTR_W-1:0]   attr_t;
	typedef logic [CELL_W-1:0]   cell_t;

	localparam action_t ACT_PUT   = 2'd0;
	localparam action_t ACT_CLEAR = 2'd1;
	localparam action_t ACT_READ  = 2'd2;

	localparam attr_t RESET_ATTR = 8'h3f;
	localparam char_t CHAR_LF    = 8'd10;
	localparam char_t CHAR_CR    = 8'd13;
	localparam char_t CHAR_BLANK = 8'd0;

endpackage

`default_nettype wire

// ===== src/tcw_cell_ram.sv =====
// tcw_cell_ram: single-port-write, single-port-read screen cell memory
// registered read; depends on tcw_pkg for the cell type
`default_nettype none

module tcw_cell_ram
	import tcw_pkg::*;
#(
	parameter int DEPTH = 2000,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire cell_t         wdata,
	input  wire logic          re,
	input  wire logic [AW-1:0] raddr,
	output cell_t              rdata
);

	cell_t cells_q [DEPTH];
	cell_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			cells_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= cells_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ===== src/text_console_writer_core.sv =====
// text_console_writer_core: character-cell text screen with cursor and scrolling
// depends on tcw_pkg and tcw_cell_ram
//
// Usage: words enter on item_valid/item_stall (action, char_code, cell_index) and
// each produces exactly one result word on result_valid/result_stall (cursor_col,
// cursor_row, scrolled, cell_char, cell_attr). attr_we/attr_wdata set the attribute
// byte for every written cell and every clear or scroll blank; write it only while the block is idle.
// The screen is a ring of rows in one memory, so a scroll only moves the top-row
// offset and blanks one row. A put without scroll, an unused action or a read beyond
// the screen is answered from the idle state; a read waits in a read state for the
// registered memory data; a put that scrolls blanks the new bottom row and a clear
// blanks every cell, one cell per write through the single memory write port.
// One word is in flight at a time; item_stall is high while busy or while a finished
// result is held by result_stall. A result waits in the output register until taken.
// After reset every cell of the memory is blanked with item_stall high;
// the attribute write port works during that pass.
`default_nettype none

module text_console_writer_core
	import tcw_pkg::*;
#(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    attr_we,
	input  wire attr_t                   attr_wdata,
	input  wire logic                    item_valid,
	output logic                         item_stall,
	input  wire action_t                 action,
	input  wire char_t                   char_code,
	input  wire logic [CELL_INDEX_W-1:0] cell_index,
	output logic                         result_valid,
	input  wire logic                    result_stall,
	output logic [CURSOR_COL_W-1:0]      cursor_col,
	output logic [CURSOR_ROW_W-1:0]      cursor_row,
	output logic                         scrolled,
	output char_t                        cell_char,
	output attr_t                        cell_attr
);

	localparam int CELL_COUNT = COLUMNS * ROWS;
	localparam int AW         = $clog2(CELL_COUNT);
	localparam int CW         = $clog2(COLUMNS);
	localparam int RW         = $clog2(ROWS);
	localparam int NW         = $clog2(CELL_COUNT + 1);

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_READ  = 2'd1;
	localparam logic [1:0] S_SWEEP = 2'd2;

	logic [1:0]    state_q;
	attr_t         attr_q;
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic [AW-1:0] row_base_q;
	logic [AW-1:0] top_off_q;
	logic [AW-1:0] sweep_addr_q;
	logic [NW-1:0] sweep_cnt_q;
	logic          sweep_emit_q;
	logic          sweep_scroll_q;
	logic          result_valid_q;

	logic [CURSOR_COL_W-1:0] cursor_col_q;
	logic [CURSOR_ROW_W-1:0] cursor_row_q;
	logic                    scrolled_q;
	char_t                   cell_char_q;
	attr_t                   cell_attr_q;

	logic          accept;
	logic          is_nl;
	logic          wrap;
	logic          idx_ok;
	logic [CW-1:0] col_d;
	logic [RW-1:0] row_d;
	logic [AW-1:0] row_base_d;
	logic [AW-1:0] top_d;
	logic          scroll_d;
	logic [AW:0]   cur_sum;
	logic [AW:0]   rd_sum;
	logic [AW:0]   top_sum;
	logic [AW-1:0] cur_addr;
	logic [AW-1:0] rd_addr;
	logic [AW-1:0] top_nxt;

	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	cell_t         ram_wdata;
	logic          ram_re;
	cell_t         ram_rdata;

	logic          res_load;
	logic [CW-1:0] res_col;
	logic [RW-1:0] res_row;
	logic          res_scr;
	cell_t         res_cell;
	logic [31:0]   res_col_w;
	logic [31:0]   res_row_w;

	assign item_stall = !(state_q == S_IDLE && (!result_valid_q || !result_stall));
	assign accept     = item_valid && !item_stall;

	// physical address: logical offset plus ring offset, one fold back into range
	always_comb begin
		cur_sum  = {1'b0, row_base_q} + (AW+1)'(col_q) + {1'b0, top_off_q};
		cur_addr = (cur_sum >= (AW+1)'(CELL_COUNT)) ?
			AW'(cur_sum - (AW+1)'(CELL_COUNT)) : cur_sum[AW-1:0];
		rd_sum   = (AW+1)'(cell_index[CELL_INDEX_W-1:0]) + {1'b0, top_off_q};
		rd_addr  = (rd_sum >= (AW+1)'(CELL_COUNT)) ?
			AW'(rd_sum - (AW+1)'(CELL_COUNT)) : rd_sum[AW-1:0];
		top_sum  = {1'b0, top_off_q} + (AW+1)'(COLUMNS);
		top_nxt  = (top_sum >= (AW+1)'(CELL_COUNT)) ?
			AW'(top_sum - (AW+1)'(CELL_COUNT)) : top_sum[AW-1:0];
		idx_ok   = 32'(cell_index) < 32'(CELL_COUNT);
	end

	always_comb begin
		is_nl      = (char_code == CHAR_LF) || (char_code == CHAR_CR);
		wrap       = is_nl || (col_q == CW'(COLUMNS - 1));
		col_d      = col_q;
		row_d      = row_q;
		row_base_d = row_base_q;
		top_d      = top_off_q;
		scroll_d   = 1'b0;
		case (action)
			ACT_PUT: begin
				if (wrap) begin
					col_d = '0;
					if (row_q == RW'(ROWS - 1)) begin
						scroll_d = 1'b1;
						top_d    = top_nxt;
					end else begin
						row_d      = row_q + RW'(1);
						row_base_d = row_base_q + AW'(COLUMNS);
					end
				end else begin
					col_d = col_q + CW'(1);
				end
			end
			ACT_CLEAR: begin
				col_d      = '0;
				row_d      = '0;
				row_base_d = '0;
				top_d      = '0;
			end
			default: ;
		endcase
	end

	// the pass after reset blanks with the reset attribute
	always_comb begin
		ram_we    = (state_q == S_SWEEP) || (accept && action == ACT_PUT && !is_nl);
		ram_waddr = (state_q == S_SWEEP) ? sweep_addr_q : cur_addr;
		ram_wdata = (state_q == S_SWEEP) ?
			{(sweep_emit_q ? attr_q : RESET_ATTR), CHAR_BLANK} : {attr_q, char_code};
		ram_re    = accept && action == ACT_READ && idx_ok;
	end

	tcw_cell_ram #(
		.DEPTH(CELL_COUNT)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(rd_addr),
		.rdata(ram_rdata)
	);

	// result source for the output register
	always_comb begin
		res_load = 1'b0;
		res_col  = col_q;
		res_row  = row_q;
		res_scr  = 1'b0;
		res_cell = '0;
		case (state_q)
			S_IDLE: begin
				if (accept && action != ACT_CLEAR && !scroll_d && !ram_re) begin
					res_load = 1'b1;
					res_col  = col_d;
					res_row  = row_d;
				end
			end
			S_READ: begin
				res_load = 1'b1;
				res_cell = ram_rdata;
			end
			S_SWEEP: begin
				res_load = sweep_emit_q && (sweep_cnt_q == NW'(1));
				res_scr  = sweep_scroll_q;
			end
			default: ;
		endcase
		res_col_w = 32'(res_col);
		res_row_w = 32'(res_row);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_SWEEP;
			attr_q         <= RESET_ATTR;
			col_q          <= '0;
			row_q          <= '0;
			row_base_q     <= '0;
			top_off_q      <= '0;
			sweep_addr_q   <= '0;
			sweep_cnt_q    <= NW'(CELL_COUNT);
			sweep_emit_q   <= 1'b0;
			sweep_scroll_q <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (attr_we) begin
				attr_q <= attr_wdata;
			end
			if (res_load) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						col_q      <= col_d;
						row_q      <= row_d;
						row_base_q <= row_base_d;
						top_off_q  <= top_d;
						if (action == ACT_CLEAR) begin
							state_q        <= S_SWEEP;
							sweep_addr_q   <= '0;
							sweep_cnt_q    <= NW'(CELL_COUNT);
							sweep_emit_q   <= 1'b1;
							sweep_scroll_q <= 1'b0;
						end else if (scroll_d) begin
							// old top row becomes the new bottom row
							state_q        <= S_SWEEP;
							sweep_addr_q   <= top_off_q;
							sweep_cnt_q    <= NW'(COLUMNS);
							sweep_emit_q   <= 1'b1;
							sweep_scroll_q <= 1'b1;
						end else if (ram_re) begin
							state_q <= S_READ;
						end
					end
				end
				S_READ: begin
					state_q <= S_IDLE;
				end
				S_SWEEP: begin
					sweep_addr_q <= sweep_addr_q + AW'(1);
					sweep_cnt_q  <= sweep_cnt_q - NW'(1);
					if (sweep_cnt_q == NW'(1)) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			cursor_col_q <= res_col_w[CURSOR_COL_W-1:0];
			cursor_row_q <= res_row_w[CURSOR_ROW_W-1:0];
			scrolled_q   <= res_scr;
			cell_char_q  <= res_cell[CHAR_W-1:0];
			cell_attr_q  <= res_cell[CELL_W-1:CHAR_W];
		end
	end

	assign result_valid = result_valid_q;
	assign cursor_col   = cursor_col_q;
	assign cursor_row   = cursor_row_q;
	assign scrolled     = scrolled_q;
	assign cell_char    = cell_char_q;
	assign cell_attr    = cell_attr_q;

	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		(32'(col_q) < 32'(COLUMNS)) && (32'(row_q) < 32'(ROWS)) &&
		(32'(top_off_q) < 32'(CELL_COUNT)))
		else $error("cursor or ring offset out of range");

	a_sweep_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SWEEP) |-> (sweep_cnt_q != '0))
		else $error("sweep running with zero count");

	a_read_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_READ) |=> (result_valid_q && state_q == S_IDLE))
		else $error("read did not deliver its result");

	a_scroll_bottom: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && scroll_d) |=> (row_q == RW'(ROWS - 1) && col_q == '0))
		else $error("scroll left cursor off the bottom row start");

endmodule

`default_nettype wire

// ===== sim/tcw_console_checker.sv =====
`timescale 1ns / 100ps
// tcw_console_checker: watches both channels of the console core, predicts every result word
// from its own screen copy and compares; depends on tcw_pkg

module tcw_console_checker
	import tcw_pkg::*;
#(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    attr_we,
	input  attr_t                   attr_wdata,
	input  logic                    item_valid,
	input  logic                    item_stall,
	input  action_t                 action,
	input  char_t                   char_code,
	input  logic [CELL_INDEX_W-1:0] cell_index,
	input  logic                    result_valid,
	input  logic                    result_stall,
	input  logic [CURSOR_COL_W-1:0] cursor_col,
	input  logic [CURSOR_ROW_W-1:0] cursor_row,
	input  logic                    scrolled,
	input  char_t                   cell_char,
	input  attr_t                   cell_attr,
	output int                      mismatch_count,
	output int                      words_pending
);

	localparam int CELLS = COLUMNS * ROWS;

	typedef struct packed {
		logic [CURSOR_COL_W-1:0] col;
		logic [CURSOR_ROW_W-1:0] row;
		logic                    scrolled;
		char_t                   ch;
		attr_t                   attr;
	} console_result_t;

	cell_t           screen [CELLS];
	int              col_pos;
	int              row_pos;
	attr_t           attr_reg;
	console_result_t expected_results [$];
	console_result_t want_word;
	console_result_t got_word;
	int              mismatches;

	function automatic void blank_screen(attr_t a);
		for (int i = 0; i < CELLS; i++)
			screen[i] = {a, CHAR_BLANK};
	endfunction

	// start of next row, scrolling the screen up when past the bottom
	function automatic logic advance_line();
		col_pos = 0;
		row_pos++;
		if (row_pos < ROWS)
			return 1'b0;
		for (int i = 0; i < CELLS - COLUMNS; i++)
			screen[i] = screen[i + COLUMNS];
		for (int i = CELLS - COLUMNS; i < CELLS; i++)
			screen[i] = {attr_reg, CHAR_BLANK};
		row_pos = ROWS - 1;
		return 1'b1;
	endfunction

	function automatic console_result_t apply_word(action_t act, char_t ch,
			logic [CELL_INDEX_W-1:0] idx);
		console_result_t r;
		r = '0;
		case (act)
		ACT_PUT: begin
			if (ch == CHAR_LF || ch == CHAR_CR) begin
				r.scrolled = advance_line();
			end else begin
				screen[row_pos * COLUMNS + col_pos] = {attr_reg, ch};
				col_pos++;
				if (col_pos >= COLUMNS)
					r.scrolled = advance_line();
			end
		end
		ACT_CLEAR: begin
			blank_screen(attr_reg);
			col_pos = 0;
			row_pos = 0;
		end
		ACT_READ: begin
			if (idx < CELLS)
				{r.attr, r.ch} = screen[idx];
		end
		default: ;
		endcase
		r.col = col_pos[CURSOR_COL_W-1:0];
		r.row = row_pos[CURSOR_ROW_W-1:0];
		return r;
	endfunction

	// word fields in reports: col, row, scrolled, char, attr
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attr_reg = RESET_ATTR;
			blank_screen(RESET_ATTR);
			col_pos = 0;
			row_pos = 0;
			expected_results.delete();
		end else begin
			if (result_valid && !result_stall) begin
				got_word = {cursor_col, cursor_row, scrolled, cell_char, cell_attr};
				if (expected_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: unexpected word %0d,%0d,%0d,%02h,%02h",
							$realtime, got_word.col, got_word.row, got_word.scrolled,
							got_word.ch, got_word.attr);
				end else begin
					want_word = expected_results.pop_front();
					if (got_word.col !== want_word.col || got_word.row !== want_word.row ||
							got_word.scrolled !== want_word.scrolled ||
							got_word.ch !== want_word.ch || got_word.attr !== want_word.attr) begin
						mismatches++;
						if (mismatches <= 10)
							$display("%0t: exp %0d,%0d,%0d,%02h,%02h got %0d,%0d,%0d,%02h,%02h",
								$realtime, want_word.col, want_word.row, want_word.scrolled,
								want_word.ch, want_word.attr, got_word.col, got_word.row,
								got_word.scrolled, got_word.ch, got_word.attr);
					end
				end
			end
			if (item_valid && !item_stall)
				expected_results.push_back(apply_word(action, char_code, cell_index));
			if (attr_we)
				attr_reg = attr_wdata;
		end
		mismatch_count <= mismatches;
		words_pending <= expected_results.size();
	end

endmodule

// ===== sim/text_console_writer_core_tb.sv =====
`timescale 1ns / 100ps
// text_console_writer_core_tb: stimulus, handshake pacing and verdict for the console core
// depends on tcw_pkg, text_console_writer_core and tcw_console_checker

module text_console_writer_core_tb;
	import tcw_pkg::*;

	localparam int COLUMNS      = 80;
	localparam int ROWS         = 25;
	localparam int CELLS        = COLUMNS * ROWS;
	localparam int INDEX_MAX    = (1 << CELL_INDEX_W) - 1;
	localparam int PHASE_WORDS  = 400;
	localparam int QUIET_LIMIT  = 50000;
	localparam int LONG_HOLD    = 300;
	localparam int DRAIN_CYCLES = 16;

	localparam action_t ACT_UNUSED = 2'd3;

	logic                    clk = 1'b0;
	logic                    arst_n;
	logic                    attr_we;
	attr_t                   attr_wdata;
	logic                    item_valid;
	logic                    item_stall;
	action_t                 action;
	char_t                   char_code;
	logic [CELL_INDEX_W-1:0] cell_index;
	logic                    result_valid;
	logic                    result_stall = 1'b0;
	logic [CURSOR_COL_W-1:0] cursor_col;
	logic [CURSOR_ROW_W-1:0] cursor_row;
	logic                    scrolled;
	char_t                   cell_char;
	attr_t                   cell_attr;

	int mismatch_count;
	int words_pending;
	int tx_idle_pct = 0;
	int rx_stall_pct = 0;
	int hold_kick = 0;
	int hold_seen = 0;
	int hold_left = 0;
	int quiet_cycles = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	text_console_writer_core #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.attr_we      (attr_we),
		.attr_wdata   (attr_wdata),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.action       (action),
		.char_code    (char_code),
		.cell_index   (cell_index),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.cursor_col   (cursor_col),
		.cursor_row   (cursor_row),
		.scrolled     (scrolled),
		.cell_char    (cell_char),
		.cell_attr    (cell_attr)
	);

	tcw_console_checker #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.attr_we        (attr_we),
		.attr_wdata     (attr_wdata),
		.item_valid     (item_valid),
		.item_stall     (item_stall),
		.action         (action),
		.char_code      (char_code),
		.cell_index     (cell_index),
		.result_valid   (result_valid),
		.result_stall   (result_stall),
		.cursor_col     (cursor_col),
		.cursor_row     (cursor_row),
		.scrolled       (scrolled),
		.cell_char      (cell_char),
		.cell_attr      (cell_attr),
		.mismatch_count (mismatch_count),
		.words_pending  (words_pending)
	);

	// result side: random stall, or a long hold-off when kicked
	always @(posedge clk) begin
		if (hold_left != 0) begin
			result_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (hold_kick != hold_seen) begin
			hold_seen <= hold_kick;
			hold_left <= LONG_HOLD - 1;
			result_stall <= 1'b1;
		end else begin
			result_stall <= rx_stall_pct != 0 && $urandom_range(99) < rx_stall_pct;
		end
	end

	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (result_valid && !result_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	task automatic send_word(action_t act, char_t ch, logic [CELL_INDEX_W-1:0] idx);
		while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		action <= act;
		char_code <= ch;
		cell_index <= idx;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
	endtask

	// waits until every result word is back, then writes the attribute
	task automatic write_attr(attr_t value);
		item_valid <= 1'b0;
		@(posedge clk);
		while (words_pending != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		attr_we <= 1'b1;
		attr_wdata <= value;
		@(posedge clk);
		attr_we <= 1'b0;
	endtask

	function automatic char_t text_char();
		int pick;
		pick = $urandom_range(99);
		if (pick < 8)
			return $urandom_range(1) ? CHAR_LF : CHAR_CR;
		if (pick < 20)
			return char_t'($urandom_range(255));
		return char_t'($urandom_range(126, 32));
	endfunction

	function automatic logic [CELL_INDEX_W-1:0] any_index();
		if ($urandom_range(19) == 0)
			return CELL_INDEX_W'($urandom_range(INDEX_MAX, CELLS));
		return CELL_INDEX_W'($urandom_range(CELLS - 1));
	endfunction

	// mostly runs of text and newlines with read-backs, some clears and noise
	task automatic run_random(int count);
		int      sent;
		int      pick;
		int      len;
		action_t act;
		sent = 0;
		while (sent < count) begin
			pick = $urandom_range(99);
			if (pick < 55) begin
				len = $urandom_range(30, 1);
				repeat (len) send_word(ACT_PUT, text_char(), any_index());
			end else if (pick < 75) begin
				len = $urandom_range(12, 1);
				repeat (len) send_word(ACT_READ, char_t'($urandom), any_index());
			end else if (pick < 84) begin
				len = $urandom_range(30, 1);
				repeat (len) send_word(ACT_PUT, $urandom_range(1) ? CHAR_LF : CHAR_CR,
					any_index());
			end else if (pick < 90) begin
				len = 0;
				send_word(ACT_UNUSED, char_t'($urandom), CELL_INDEX_W'($urandom));
			end else if (pick < 94) begin
				len = 1;
				send_word(ACT_CLEAR, char_t'($urandom), CELL_INDEX_W'($urandom));
			end else begin
				act = action_t'($urandom_range(3));
				len = (act == ACT_UNUSED) ? 0 : 1;
				send_word(act, char_t'($urandom), CELL_INDEX_W'($urandom));
			end
			sent += len;
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		attr_we <= 1'b0;
		attr_wdata <= '0;
		item_valid <= 1'b0;
		action <= ACT_PUT;
		char_code <= '0;
		cell_index <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// reset contents, out-of-range reads, unused action, puts, newlines, read-backs and a clear
		send_word(ACT_READ, 8'h00, CELL_INDEX_W'(0));
		send_word(ACT_READ, 8'hff, CELL_INDEX_W'(CELLS - 1));
		send_word(ACT_READ, 8'h00, CELL_INDEX_W'(CELLS));
		send_word(ACT_READ, 8'h00, CELL_INDEX_W'(INDEX_MAX));
		send_word(ACT_UNUSED, 8'hff, CELL_INDEX_W'(INDEX_MAX));
		send_word(ACT_PUT, 8'h41, CELL_INDEX_W'(0));
		send_word(ACT_PUT, 8'hff, CELL_INDEX_W'(INDEX_MAX));
		send_word(ACT_PUT, 8'h00, CELL_INDEX_W'(0));
		send_word(ACT_PUT, CHAR_CR, CELL_INDEX_W'(0));
		send_word(ACT_PUT, CHAR_LF, CELL_INDEX_W'(0));
		send_word(ACT_PUT, 8'h7e, CELL_INDEX_W'(0));
		send_word(ACT_READ, 8'h00, CELL_INDEX_W'(0));
		send_word(ACT_READ, 8'h00, CELL_INDEX_W'(1));
		send_word(ACT_READ, 8'h00, CELL_INDEX_W'(2));
		send_word(ACT_READ, 8'h00, CELL_INDEX_W'(2 * COLUMNS));
		send_word(ACT_CLEAR, 8'hff, CELL_INDEX_W'(INDEX_MAX));
		send_word(ACT_READ, 8'h00, CELL_INDEX_W'(0));
		send_word(ACT_READ, 8'h00, CELL_INDEX_W'(2 * COLUMNS));

		write_attr(8'h00);
		run_random(PHASE_WORDS);

		write_attr(8'hff);
		tx_idle_pct <= 51;
		run_random(PHASE_WORDS);

		write_attr(attr_t'($urandom));
		tx_idle_pct <= 0;
		rx_stall_pct <= 51;
		// long hold-off up front so the core backs up and stalls its input
		hold_kick <= hold_kick + 1;
		run_random(PHASE_WORDS);

		write_attr(attr_t'($urandom));
		tx_idle_pct <= 35;
		rx_stall_pct <= 35;
		run_random(PHASE_WORDS);

		item_valid <= 1'b0;
		@(posedge clk);
		while (words_pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && words_pending == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
